FILE: hdl/spt_pkg.sv
// Shared widths, table entry record and controller/datapath interface types.
package spt_pkg;

  localparam int ADDR_W   = 48;
  localparam int STRIDE_W = 32;
  localparam int IN_W     = 96;
  localparam int OUT_W    = 48;
  localparam int OUTU_W   = 2;

  // One table entry as stored in the entry memory
  typedef struct packed {
    logic [ADDR_W-1:0]   pc;
    logic [ADDR_W-1:0]   last_addr;
    logic [STRIDE_W-1:0] stride;
    logic                known;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } spt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic done;
    logic out_free;
  } spt_status_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } spt_state_t;

endpackage

FILE: hdl/spt_ctrl.sv
// Control state machine: accept, table scan, commit of the result.
module spt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spt_pkg::spt_status_t status,
  output spt_pkg::spt_cmd_t    cmd
);
  import spt_pkg::*;

  spt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.hit || status.done) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/spt_datapath.sv
// Datapath: entry memory, sequential tag scan, stride learning and output register.
module spt_datapath #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [spt_pkg::IN_W-1:0]   in_data,
  input  logic                       cfg_wr_en,
  input  logic [spt_pkg::ADDR_W-1:0] cfg_wr_data,
  input  spt_pkg::spt_cmd_t          cmd,
  output spt_pkg::spt_status_t       status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [spt_pkg::OUT_W-1:0]  out_data,
  output logic [spt_pkg::OUTU_W-1:0] out_user
);
  import spt_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  entry_t mem [TABLE_ENTRIES];

  logic [ADDR_W-1:0] pc_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] address_limit;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     fill;
  logic [AW-1:0]     rptr;
  logic [AW-1:0]     rd_idx;
  logic              rd_pend;
  entry_t            rd_entry;

  logic              rd_en;
  logic              hit;
  logic              wr_en;
  logic [AW-1:0]     wr_idx;
  entry_t            wr_entry;
  logic signed [ADDR_W:0]   diff;
  logic [STRIDE_W-1:0]      sat_stride;
  logic signed [ADDR_W+1:0] sum;
  logic              pf_valid;
  logic [ADDR_W-1:0] pf_addr;

  // Address limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      address_limit <= '1;
    end else if (cfg_wr_en) begin
      address_limit <= cfg_wr_data;
    end
  end

  // Captured transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pc_q   <= in_data[ADDR_W-1:0];
      addr_q <= in_data[2*ADDR_W-1:ADDR_W];
    end
  end

  // Scan counter: one entry read per cycle over the filled part of the table
  assign rd_en = cmd.scan && (idx < fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.load) begin
      idx     <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.scan) begin
      rd_pend <= rd_en;
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Entry memory: registered read, single write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[idx[AW-1:0]];
      rd_idx   <= idx[AW-1:0];
    end
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  assign hit             = rd_pend && (rd_entry.pc == pc_q);
  assign status.hit      = hit;
  assign status.done     = !rd_pend && !(idx < fill);
  assign status.out_free = !out_valid || out_ready;

  // Stride between this access and the last one, saturated to 32 bits signed
  assign diff = $signed({1'b0, addr_q}) - $signed({1'b0, rd_entry.last_addr});
  always_comb begin
    if (diff[ADDR_W:STRIDE_W-1] == {(ADDR_W-STRIDE_W+2){diff[ADDR_W]}}) begin
      sat_stride = diff[STRIDE_W-1:0];
    end else if (diff[ADDR_W]) begin
      sat_stride = {1'b1, {(STRIDE_W-1){1'b0}}};
    end else begin
      sat_stride = {1'b0, {(STRIDE_W-1){1'b1}}};
    end
  end

  // Proposal: access address plus learned stride, in range (0, limit)
  assign sum = $signed({2'b00, addr_q})
             + $signed({{(ADDR_W+2-STRIDE_W){rd_entry.stride[STRIDE_W-1]}}, rd_entry.stride});
  assign pf_valid = hit && rd_entry.known && !sum[ADDR_W+1] && (sum != '0)
                 && (sum[ADDR_W:0] < {1'b0, address_limit});
  assign pf_addr  = pf_valid ? sum[ADDR_W-1:0] : '0;

  // Entry update: new entry on a miss, stride learned on the second access
  always_comb begin
    wr_en    = cmd.commit && (!hit || !rd_entry.known);
    wr_idx   = hit ? rd_idx : rptr;
    wr_entry.pc        = pc_q;
    wr_entry.last_addr = addr_q;
    wr_entry.stride    = hit ? sat_stride : '0;
    wr_entry.known     = hit;
  end

  // Replacement pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rptr <= '0;
      fill <= '0;
    end else if (cmd.commit && !hit) begin
      rptr <= (rptr == LAST_IDX) ? '0 : rptr + 1'b1;
      if (fill != FULL_CNT) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= pf_addr;
      out_user <= {pf_valid, hit};
    end
  end

endmodule

FILE: hdl/stride_prefetch_table.sv
// Stride prefetch table: PC-keyed table that learns strides and proposes prefetches.
//
// Usage: each slave-side transaction carries one memory access (PC and address).
// The block looks the PC up in a fully associative table of TABLE_ENTRIES entries,
// scanning the entry memory one entry per cycle over the entries filled so far.
// A miss installs the access at a round-robin slot; a second access by the same PC
// learns the stride; every later access proposes address plus stride when that sum
// is above zero and below the address limit register (cfg_wr_en / cfg_wr_data).
// Exactly one master-side transaction is produced per access.
// The time from one accepted transaction to the next grows with the table slot of
// a hit, or on a miss with the number of filled entries (at most TABLE_ENTRIES), as
// the scan goes through the single read port of the entry memory. The result is
// registered; the next access is taken only once the last one has been committed.
// Reset empties the table, rewinds the replacement slot and sets the limit to all
// ones. A stalled master side holds the result in the output register; the next
// access is still taken and scanned, and only waits to commit until that result
// has been taken.
module stride_prefetch_table #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  // tdata: access_pc [47:0], access_addr [95:48]
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [spt_pkg::IN_W-1:0]     s_axis_tdata,
  // tdata: prefetch_addr [47:0]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [spt_pkg::OUT_W-1:0]    m_axis_tdata,
  // tuser: table_hit [0], prefetch_valid [1]
  output logic [spt_pkg::OUTU_W-1:0]   m_axis_tuser,
  input  logic                         cfg_wr_en,
  input  logic [spt_pkg::ADDR_W-1:0]   cfg_wr_data
);
  import spt_pkg::*;

  spt_cmd_t    cmd;
  spt_status_t status;

  spt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  spt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_user    (m_axis_tuser)
  );

  // One access in flight: no new transaction right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("access accepted while previous one in flight");

  // A prefetch is only proposed on a table hit
  a_pf_needs_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("prefetch proposed without a table hit");

  // No proposal means a zero address
  a_no_pf_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata == '0)
    else $error("nonzero prefetch address without proposal");

  // Results are committed only into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !m_axis_tvalid || m_axis_tready)
    else $error("result committed over a pending transaction");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for stride_prefetch_table: stream stimulus, prediction and result checks.

// Expected-result store and table predictor for the stride prefetch table.
class prefetch_scoreboard;
  localparam int TABLE_SIZE = 256;
  localparam logic [spt_pkg::ADDR_W-1:0] ADDR_MAX = '1;

  typedef struct {
    logic                      hit;
    logic                      prefetch;
    logic [spt_pkg::ADDR_W-1:0] target;
  } prefetch_result_t;

  // Local copy of the table state
  logic                          slot_valid [TABLE_SIZE];
  logic [spt_pkg::ADDR_W-1:0]    slot_pc    [TABLE_SIZE];
  logic [spt_pkg::ADDR_W-1:0]    slot_addr  [TABLE_SIZE];
  logic signed [spt_pkg::STRIDE_W-1:0] slot_stride [TABLE_SIZE];
  logic                          slot_known [TABLE_SIZE];
  int unsigned                   next_slot;
  logic [spt_pkg::ADDR_W-1:0]    addr_limit;

  prefetch_result_t expected_results [$];
  int failures;
  int accesses;
  int hits;
  int proposals;
  int results_seen;

  function new();
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    next_slot  = 0;
    addr_limit = ADDR_MAX;
    failures   = 0;
    accesses   = 0;
    hits       = 0;
    proposals  = 0;
    results_seen = 0;
  endfunction

  function void set_limit(logic [spt_pkg::ADDR_W-1:0] value);
    addr_limit = value;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Predict the result of one accepted access and update the table copy
  function void note_access(logic [spt_pkg::ADDR_W-1:0] pc, logic [spt_pkg::ADDR_W-1:0] addr);
    prefetch_result_t res;
    int   slot;
    bit   found;
    longint diff;
    longint sum;
    res = '{hit: 1'b0, prefetch: 1'b0, target: '0};
    found = 0;
    slot  = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (slot_valid[i] && slot_pc[i] == pc) begin
        slot  = i;
        found = 1;
        break;
      end
    end
    if (!found) begin
      slot_valid[next_slot]  = 1'b1;
      slot_pc[next_slot]     = pc;
      slot_addr[next_slot]   = addr;
      slot_stride[next_slot] = '0;
      slot_known[next_slot]  = 1'b0;
      next_slot = (next_slot + 1) % TABLE_SIZE;
    end else if (!slot_known[slot]) begin
      // second access learns the stride, clamped to 32-bit signed
      diff = longint'(addr) - longint'(slot_addr[slot]);
      if (diff > longint'(32'sh7FFF_FFFF))
        slot_stride[slot] = 32'sh7FFF_FFFF;
      else if (diff < -longint'(64'sd2147483648))
        slot_stride[slot] = 32'sh8000_0000;
      else
        slot_stride[slot] = diff[31:0];
      slot_addr[slot]  = addr;
      slot_known[slot] = 1'b1;
      res.hit = 1'b1;
    end else begin
      res.hit = 1'b1;
      sum = longint'(addr) + longint'(slot_stride[slot]);
      if (sum > 0 && sum < longint'(addr_limit)) begin
        res.prefetch = 1'b1;
        res.target   = sum[spt_pkg::ADDR_W-1:0];
      end
    end
    accesses++;
    if (res.hit) hits++;
    if (res.prefetch) proposals++;
    expected_results.push_back(res);
  endfunction

  // Compare one result transaction with the oldest prediction
  function void check_result(logic hit, logic prefetch, logic [spt_pkg::ADDR_W-1:0] target);
    prefetch_result_t exp_res;
    results_seen++;
    if (expected_results.size() == 0) begin
      $error("result with no access outstanding: hit=%0b prefetch=%0b addr=%h",
             hit, prefetch, target);
      failures++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (hit !== exp_res.hit) begin
      $error("table_hit: expected %0b, got %0b", exp_res.hit, hit);
      failures++;
    end
    if (prefetch !== exp_res.prefetch) begin
      $error("prefetch_valid: expected %0b, got %0b", exp_res.prefetch, prefetch);
      failures++;
    end
    if (target !== exp_res.target) begin
      $error("prefetch_addr: expected %h, got %h", exp_res.target, target);
      failures++;
    end
  endfunction
endclass

module tb_top;
  import spt_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int POOL          = 48;
  localparam int PHASE_ITEMS   = 175;
  localparam int EVICT_ITEMS   = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 300;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;     // access_pc [47:0], access_addr [95:48]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;          // prefetch_addr [47:0]
  logic [OUTU_W-1:0]  m_axis_tuser;          // table_hit [0], prefetch_valid [1]
  logic               cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0]  cfg_wr_data = '0;

  prefetch_scoreboard sb = new();

  // Stall control for sender and receiver, cycle and limit-write counters
  bit steady    = 0;
  bit want_hold = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int cycles    = 0;
  int limit_writes = 0;

  // Access streams: one PC walking through memory with a fixed step
  logic [ADDR_W-1:0] stream_pc   [POOL];
  logic [ADDR_W-1:0] stream_addr [POOL];
  logic [ADDR_W-1:0] stream_step [POOL];

  stride_prefetch_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("stride_prefetch_table verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (want_hold && !hold_done && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 35);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata);
  end

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  // Offer one access; valid stays high afterwards so back-to-back offers need no toggle
  task automatic send_access(input logic [ADDR_W-1:0] pc, input logic [ADDR_W-1:0] addr);
    if (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    s_axis_tdata  <= {addr, pc};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_access(pc, addr);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // Drain outstanding results, then let the block settle
  task automatic wait_idle();
    stop_sending();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ADDR_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(value);
    limit_writes++;
  endtask

  // Start a fresh stream: new PC, base near zero, near the top, or anywhere
  task automatic new_stream(input int k);
    int r;
    r = $urandom_range(99);
    stream_pc[k] = rand48();
    if (r < 15)
      stream_addr[k] = ADDR_W'($urandom_range(5000));
    else if (r < 30)
      stream_addr[k] = ADDR_MAX - ADDR_W'($urandom_range(5000));
    else
      stream_addr[k] = rand48();
    r = $urandom_range(99);
    if (r < 55)
      stream_step[k] = ADDR_W'($urandom_range(4096, 1));
    else if (r < 65)
      stream_step[k] = -ADDR_W'($urandom_range(4096, 1));
    else if (r < 75)
      stream_step[k] = '0;
    else if (r < 88)
      stream_step[k] = {{17{1'($urandom_range(1))}}, 31'($urandom)};
    else
      stream_step[k] = rand48();   // mostly beyond the 32-bit stride range
  endtask

  // One random access: mostly stream walks, some noise and one-off PCs
  task automatic random_access();
    int r;
    int k;
    r = $urandom_range(99);
    k = $urandom_range(POOL - 1);
    if (r < 3) begin
      new_stream(k);
      send_access(stream_pc[k], stream_addr[k]);
    end else if (r < 13) begin
      send_access(stream_pc[k], rand48());
    end else if (r < 18) begin
      send_access(rand48(), rand48());
    end else begin
      stream_addr[k] = stream_addr[k] + stream_step[k];
      send_access(stream_pc[k], stream_addr[k]);
    end
  endtask

  logic [ADDR_W-1:0] phase_limit [7];

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: learn, propose, clamp the stride both ways, limit and zero boundaries
    send_access('0, '0);
    send_access('0, 48'd100);
    send_access('0, 48'd200);
    send_access(ADDR_MAX, ADDR_MAX);
    send_access(ADDR_MAX, '0);                   // stride clamps to most negative
    send_access(ADDR_MAX, 48'h0000_8000_0000);   // sum is exactly zero
    send_access(ADDR_MAX, 48'd5);                // sum negative
    send_access(ADDR_MAX, ADDR_MAX);
    send_access(48'd1, '0);
    send_access(48'd1, ADDR_MAX);                // stride clamps to most positive
    send_access(48'd1, ADDR_MAX);                // sum beyond 48 bits
    send_access(48'd1, ADDR_MAX - 48'h0000_8000_0000);
    send_access(48'd1, ADDR_MAX - 48'h0000_7FFF_FFFF); // sum equals the limit
    send_access(48'd2, 48'd1000);
    send_access(48'd2, 48'd1000);                // zero stride
    send_access(48'd2, 48'd1000);
    send_access(48'd2, '0);
    send_access(48'd3, 48'd500);
    send_access(48'd3, 48'd400);                 // negative stride
    send_access(48'd3, 48'd101);
    send_access(48'd3, 48'd100);
    write_limit(48'd1000);
    send_access(48'd2, 48'd999);
    send_access(48'd2, 48'd1000);
    write_limit('0);
    send_access('0, 48'd1);

    // Random phases over several limit settings
    phase_limit[0] = ADDR_MAX;
    phase_limit[1] = '0;
    phase_limit[2] = 48'd1;
    phase_limit[3] = rand48();
    phase_limit[4] = 48'h8000_0000_0000;
    phase_limit[5] = ADDR_MAX;
    phase_limit[6] = {1'b1, 47'(rand48())};
    for (int k = 0; k < POOL; k++) new_stream(k);

    for (int p = 0; p < 7; p++) begin
      write_limit(phase_limit[p]);
      steady = (p == 2);
      if (p == 4) want_hold = 1;
      // replacement wraps: a run of fresh PCs pushes every stream out of the table
      if (p == 5)
        for (int n = 0; n < EVICT_ITEMS; n++) send_access(rand48(), rand48());
      for (int n = 0; n < PHASE_ITEMS; n++) random_access();
      steady = 0;
    end

    stop_sending();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d accesses (%0d table hits, %0d prefetch proposals)",
             sb.accesses, sb.hits, sb.proposals);
    $display("across %0d limit writes; results seen: %0d, mismatches: %0d, cycles: %0d.",
             limit_writes, sb.results_seen, sb.failures, cycles);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("stride_prefetch_table verification clean");
    else
      $display("stride_prefetch_table verification failed");
    $finish;
  end
endmodule
